/* hdl/clist_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clist_pkg: shared types and constants for the cursor list engine
// Request and response payloads, command and status codes, and the control
// word that the controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package clist_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_SET_CURSOR = 3'd2,
    CMD_READ       = 3'd3,
    CMD_OVERWRITE  = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [4:0]               count;
    logic [3:0]               cursor_index;
    logic [1:0]               status;
  } rsp_t;

  // One control word drives the whole chain of cells.
  typedef struct packed {
    logic                     shift_in_front;
    logic                     shift_out;
    logic                     load_back;
    logic                     load_cursor;
    logic [IDX_W-1:0]         cursor;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* hdl/clist_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clist_cell: one storage cell of the list chain
// Holds the element at its position and takes a new value from the request,
// from its left neighbor (push at front) or its right neighbor (remove).
// ----------------------------------------------------------------------------
module clist_cell (
  input  logic                                      clk_i,
  input  logic [clist_pkg::IDX_W-1:0]               index_i,
  input  clist_pkg::cell_ctrl_t                     ctrl_i,
  input  logic signed [clist_pkg::DATA_W-1:0]       left_i,
  input  logic signed [clist_pkg::DATA_W-1:0]       right_i,
  output logic signed [clist_pkg::DATA_W-1:0]       entry_o
);

  logic signed [clist_pkg::DATA_W-1:0] entry_q, entry_d;
  logic [clist_pkg::CNT_W-1:0]         index_ext;

  assign index_ext = clist_pkg::CNT_W'(index_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in_front) begin
      entry_d = left_i;
    end else if (ctrl_i.shift_out && (index_i >= ctrl_i.cursor)) begin
      // close the gap: everything at and behind the cursor moves forward
      entry_d = right_i;
    end else if (ctrl_i.load_back && (index_ext == ctrl_i.count)) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.load_cursor && (index_i == ctrl_i.cursor)) begin
      entry_d = ctrl_i.value;
    end
  end

  // hold the element; positions at or beyond the count are never read
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

/* hdl/clist_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clist_ctrl: command decode, count and cursor state, result register
// Decodes one request per cycle, drives the cell chain control word and
// registers the response together with its strobe.
// ----------------------------------------------------------------------------
module clist_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  clist_pkg::req_t                     req_i,
  input  logic signed [clist_pkg::DATA_W-1:0] rd_data_i,
  output logic [clist_pkg::IDX_W-1:0]         cursor_o,
  output clist_pkg::cell_ctrl_t               ctrl_o,
  output clist_pkg::rsp_t                     rsp_o,
  output logic                                done_o
);

  logic [clist_pkg::CNT_W-1:0]         count_q, count_d;
  logic [clist_pkg::IDX_W-1:0]         cursor_q, cursor_d;
  logic                                done_q;
  clist_pkg::rsp_t                     rsp_q, rsp_d;
  logic                                full, empty;
  logic [clist_pkg::CNT_W-1:0]         count_dec;
  logic signed [clist_pkg::DATA_W-1:0] data;
  clist_pkg::status_e                  status;

  assign full      = (count_q == clist_pkg::CNT_W'(clist_pkg::CAPACITY));
  assign empty     = (count_q == '0);
  assign count_dec = count_q - clist_pkg::CNT_W'(1);

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    data     = '0;
    status   = clist_pkg::STATUS_OK;
    ctrl_o   = '0;
    ctrl_o.cursor = cursor_q;
    ctrl_o.count  = count_q;
    ctrl_o.value  = req_i.value;
    if (accept_i) begin
      case (req_i.cmd)
        clist_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status = clist_pkg::STATUS_FULL;
          end else begin
            ctrl_o.load_back = 1'b1;
            count_d          = count_q + clist_pkg::CNT_W'(1);
            if (empty) cursor_d = '0;
          end
        end
        clist_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status = clist_pkg::STATUS_FULL;
          end else begin
            ctrl_o.shift_in_front = 1'b1;
            count_d               = count_q + clist_pkg::CNT_W'(1);
            // follow the element that the cursor points at
            cursor_d = empty ? '0 : cursor_q + clist_pkg::IDX_W'(1);
          end
        end
        clist_pkg::CMD_SET_CURSOR: begin
          if ((req_i.position != '0) &&
              (req_i.position < clist_pkg::POS_W'(count_q))) begin
            cursor_d = req_i.position[clist_pkg::IDX_W-1:0];
          end else begin
            cursor_d = '0;
          end
        end
        clist_pkg::CMD_READ: begin
          if (empty) status = clist_pkg::STATUS_EMPTY;
          else       data   = rd_data_i;
        end
        clist_pkg::CMD_OVERWRITE: begin
          if (empty) begin
            data   = req_i.value;
            status = clist_pkg::STATUS_EMPTY;
          end else begin
            data               = rd_data_i;
            ctrl_o.load_cursor = 1'b1;
          end
        end
        clist_pkg::CMD_REMOVE: begin
          if (empty) begin
            status = clist_pkg::STATUS_EMPTY;
          end else begin
            data             = rd_data_i;
            ctrl_o.shift_out = 1'b1;
            count_d          = count_dec;
            if (count_dec == '0) begin
              cursor_d = '0;
            end else if (clist_pkg::CNT_W'(cursor_q) >= count_dec) begin
              // removed the tail: step back to the new last element
              cursor_d = count_dec[clist_pkg::IDX_W-1:0] - clist_pkg::IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
    rsp_d.data         = data;
    rsp_d.count        = 5'(count_d);
    rsp_d.cursor_index = 4'(cursor_d);
    rsp_d.status       = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      done_q   <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) rsp_q <= rsp_d;
  end

  assign cursor_o = cursor_q;
  assign rsp_o    = rsp_q;
  assign done_o   = done_q;

endmodule
`default_nettype wire

/* hdl/cursor_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_list_engine: ordered list of signed values with a cursor
// A chain of storage cells that shift toward the back on push at front and
// toward the front on remove, plus a controller for count and cursor.
// ----------------------------------------------------------------------------
// A request accepted at a clock edge has its response on rsp_o in the cycle
// after it, with done_o high for a single cycle; rsp_o holds it until the
// next accepted request. The whole cell chain shifts or loads at that edge,
// so busy stays low and a new request can be issued every cycle. The receiver
// cannot stall the block; take each response in the cycle that done_o is high.
module cursor_list_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  clist_pkg::req_t req_i,
  output clist_pkg::rsp_t rsp_o,
  output logic            done_o
);

  logic                                accept;
  logic [clist_pkg::IDX_W-1:0]         cursor;
  clist_pkg::cell_ctrl_t               cell_ctrl;
  logic signed [clist_pkg::DATA_W-1:0] entries [clist_pkg::CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  clist_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req_i),
    .rd_data_i (entries[cursor]),
    .cursor_o  (cursor),
    .ctrl_o    (cell_ctrl),
    .rsp_o     (rsp_o),
    .done_o    (done_o)
  );

  for (genvar i = 0; i < clist_pkg::CAPACITY; i++) begin : g_cell
    logic signed [clist_pkg::DATA_W-1:0] left, right;
    if (i == 0) begin : g_head
      assign left = req_i.value;
    end else begin : g_body
      assign left = entries[i-1];
    end
    if (i == clist_pkg::CAPACITY - 1) begin : g_tail
      assign right = entries[i];
    end else begin : g_inner
      assign right = entries[i+1];
    end
    clist_cell u_cell (
      .clk_i   (clk_i),
      .index_i (clist_pkg::IDX_W'(i)),
      .ctrl_i  (cell_ctrl),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[i])
    );
  end

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("response strobe missing after request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("response strobe without request");

  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.count == '0) |-> (rsp_o.cursor_index == '0))
    else $error("cursor not at zero on empty list");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == clist_pkg::STATUS_FULL) |->
    (rsp_o.count == 5'(clist_pkg::CAPACITY)))
    else $error("full flag on a list that is not full");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.count != '0) |->
    (5'(rsp_o.cursor_index) < rsp_o.count))
    else $error("cursor beyond last element");

endmodule
`default_nettype wire
